/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/spibd_pkg.sv */
// ----------------------------------------------------------------------------
// SPI baud divisor search package
// Widths, table sizes and register constants of the divisor search unit.
// ----------------------------------------------------------------------------
package spibd_pkg;

	localparam int NUM_SCALERS    = 9;
	localparam int NUM_PRESCALERS = 8;

	localparam int KHZ_W    = 22;
	localparam int BAUD_W   = 32;
	localparam int PRE_W    = 3;
	localparam int SCL_W    = 4;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [KHZ_W-1:0]  KHZ_RESET = KHZ_W'(24000);
	localparam logic [BAUD_W-1:0] KHZ_TO_HZ = BAUD_W'(1000);

	// Register index of the bus clock register.
	localparam logic REG_BUS_CLOCK_KHZ = 1'b0;

	// Quotient bits resolved per divider cycle.
	localparam int DIV_STEP = 8;
	localparam int DIV_CYCLES = BAUD_W / DIV_STEP;

endpackage

/* rtl/core/spi_baud_divisor_search_unit.sv */
// Flow: an accepted item passes the multiply step, the divider steps, the candidate
// compare steps and the writeback step, which waits while out_valid is held unread.
// A new item is accepted only in idle, after writeback, as the divider and comparator are shared.
// A finished result may wait in the output register while the next item runs.
// Reset: arst_n clears the sequencer and out_valid and sets bus_clock_khz to 24000.
// ----------------------------------------------------------------------------
// SPI baud divisor search unit
// Finds the prescaler and power-of-two scaler pair whose baud best matches
// the requested rate, using one shared divider and one shared comparator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_baud_divisor_search_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [spibd_pkg::PADDR_W-1:0]     paddr,
	input  logic [spibd_pkg::PDATA_W-1:0]     pwdata,
	output logic [spibd_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [spibd_pkg::BAUD_W-1:0]      target_baud,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [spibd_pkg::PRE_W-1:0]       prescale_index,
	output logic [spibd_pkg::SCL_W-1:0]       scale_index,
	output logic [spibd_pkg::BAUD_W-1:0]      achieved_baud,
	output logic                              too_fast
);
	import spibd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SRCH,
		ST_WB
	} state_t;

	localparam int DCNT_W = $clog2(DIV_CYCLES);
	localparam int SHAMT_W = $clog2(BAUD_W) + 1;

	state_t                  state_q;
	logic [KHZ_W-1:0]        khz_q;
	logic [BAUD_W-1:0]       target_q;
	logic [BAUD_W-1:0]       bus_hz_q;
	logic [BAUD_W-1:0]       dvd_q;
	logic [BAUD_W-1:0]       quot_q;
	logic [PRE_W-1:0]        rem_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic [PRE_W-1:0]        p_cnt_q;
	logic [SCL_W-1:0]        s_cnt_q;
	logic [BAUD_W-1:0]       q_arr_q [NUM_PRESCALERS];
	logic [BAUD_W-1:0]       best_diff_q;
	logic [BAUD_W-1:0]       best_q_q;
	logic [PRE_W-1:0]        best_p_q;
	logic [SCL_W-1:0]        best_s_q;
	logic                    out_valid_q;
	logic [PRE_W-1:0]        pre_idx_q;
	logic [SCL_W-1:0]        scl_idx_q;
	logic [BAUD_W-1:0]       achieved_q;
	logic                    too_fast_q;

	logic                    cfg_wr;
	logic [BAUD_W-1:0]       hz_prod;
	logic [PRE_W:0]          divisor;
	logic [PRE_W-1:0]        rem_nxt;
	logic [BAUD_W-1:0]       dvd_nxt;
	logic [DIV_STEP-1:0]     qbits;
	logic [SHAMT_W-1:0]      shamt;
	logic [BAUD_W-1:0]       q_cand;
	logic [BAUD_W-1:0]       diff;
	logic                    first_cand;
	logic                    better;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[PADDR_W-1] == REG_BUS_CLOCK_KHZ);

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1] == REG_BUS_CLOCK_KHZ) begin
			prdata = PDATA_W'(khz_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			khz_q <= KHZ_RESET;
		end else if (cfg_wr) begin
			khz_q <= pwdata[KHZ_W-1:0];
		end
	end

	assign hz_prod = BAUD_W'(khz_q) * KHZ_TO_HZ;
	assign divisor = {1'b0, p_cnt_q} + (PRE_W+1)'(1);

	always_comb begin
		logic [PRE_W:0] rem_ext;
		rem_nxt = rem_q;
		dvd_nxt = dvd_q;
		qbits = '0;
		rem_ext = '0;
		for (int k = 0; k < DIV_STEP; k++) begin
			rem_ext = {rem_nxt, dvd_nxt[BAUD_W-1]};
			dvd_nxt = {dvd_nxt[BAUD_W-2:0], 1'b0};
			if (rem_ext >= divisor) begin
				rem_ext = rem_ext - divisor;
				qbits = {qbits[DIV_STEP-2:0], 1'b1};
			end else begin
				qbits = {qbits[DIV_STEP-2:0], 1'b0};
			end
			rem_nxt = rem_ext[PRE_W-1:0];
		end
	end

	assign shamt = SHAMT_W'(s_cnt_q) + SHAMT_W'(1);
	assign q_cand = q_arr_q[p_cnt_q] >> shamt;
	assign diff = (q_cand > target_q) ? (q_cand - target_q) : (target_q - q_cand);
	assign first_cand = (p_cnt_q == '0) && (s_cnt_q == '0);
	assign better = first_cand || (diff < best_diff_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			dcnt_q <= '0;
			p_cnt_q <= '0;
			s_cnt_q <= '0;
			rem_q <= '0;
			target_q <= '0;
			bus_hz_q <= '0;
			dvd_q <= '0;
			quot_q <= '0;
			best_diff_q <= '0;
			best_q_q <= '0;
			best_p_q <= '0;
			best_s_q <= '0;
			pre_idx_q <= '0;
			scl_idx_q <= '0;
			achieved_q <= '0;
			too_fast_q <= 1'b0;
			for (int i = 0; i < NUM_PRESCALERS; i++) begin
				q_arr_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_WB)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						target_q <= target_baud;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					bus_hz_q <= hz_prod;
					dvd_q <= hz_prod;
					rem_q <= '0;
					dcnt_q <= '0;
					p_cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					quot_q <= {quot_q[BAUD_W-DIV_STEP-1:0], qbits};
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DCNT_W'(DIV_CYCLES - 1)) begin
						q_arr_q[p_cnt_q] <= {quot_q[BAUD_W-DIV_STEP-1:0], qbits};
						dvd_q <= bus_hz_q;
						rem_q <= '0;
						if (p_cnt_q == PRE_W'(NUM_PRESCALERS - 1)) begin
							p_cnt_q <= '0;
							s_cnt_q <= '0;
							state_q <= ST_SRCH;
						end else begin
							p_cnt_q <= p_cnt_q + PRE_W'(1);
						end
					end else begin
						dvd_q <= dvd_nxt;
						rem_q <= rem_nxt;
					end
				end
				ST_SRCH: begin
					if (better) begin
						best_diff_q <= diff;
						best_q_q <= q_cand;
						best_p_q <= p_cnt_q;
						best_s_q <= s_cnt_q;
					end
					if (p_cnt_q == PRE_W'(NUM_PRESCALERS - 1)) begin
						p_cnt_q <= '0;
						if (s_cnt_q == SCL_W'(NUM_SCALERS - 1)) begin
							s_cnt_q <= '0;
							state_q <= ST_WB;
						end else begin
							s_cnt_q <= s_cnt_q + SCL_W'(1);
						end
					end else begin
						p_cnt_q <= p_cnt_q + PRE_W'(1);
					end
				end
				ST_WB: begin
					if (!out_valid_q || out_ready) begin
						pre_idx_q <= best_p_q;
						scl_idx_q <= best_s_q;
						achieved_q <= best_q_q;
						too_fast_q <= (best_q_q > {1'b0, bus_hz_q[BAUD_W-1:1]});
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign prescale_index = pre_idx_q;
	assign scale_index = scl_idx_q;
	assign achieved_baud = achieved_q;
	assign too_fast = too_fast_q;

	`ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`ASSERT_SAME(a_scale_in_range, out_valid, scale_index <= SCL_W'(NUM_SCALERS - 1))
	`ASSERT_SAME(a_never_too_fast, out_valid, !too_fast)
	`ASSERT_SAME(a_search_bounds, state_q == ST_SRCH, s_cnt_q <= SCL_W'(NUM_SCALERS - 1))

endmodule
